@@ sv/weighted_roulette_picker_assert.svh @@
`ifndef WEIGHTED_ROULETTE_PICKER_ASSERT_SVH
`define WEIGHTED_ROULETTE_PICKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define WRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define WRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/wrp_pkg.sv @@
package wrp_pkg;

    localparam int MAX_METHODS = 4;
    localparam int W_MODE      = 2;
    localparam int W_MASK      = 4;
    localparam int W_WEIGHT    = 16;
    localparam int W_FRAC      = 16;
    localparam int W_IDX       = 2;
    localparam int W_EFF       = W_WEIGHT + 1;
    localparam int W_TOTAL     = W_WEIGHT + 2;
    localparam int W_PROD      = W_TOTAL + W_FRAC;

    localparam logic [W_MODE-1:0] MODE_PICK  = 2'd0;
    localparam logic [W_MODE-1:0] MODE_CLEAR = 2'd1;
    localparam logic [W_MODE-1:0] MODE_LOAD  = 2'd2;

    typedef struct packed {
        logic [W_MODE-1:0]                        mode;
        logic [W_MASK-1:0]                        usable_mask;
        logic [MAX_METHODS-1:0][W_WEIGHT-1:0]     weight;
        logic [W_FRAC-1:0]                        random_fraction;
    } t_item;

    typedef struct packed {
        logic capture;
        logic sum;
        logic mul;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_MUL  = 4'b0100,
        S_PICK = 4'b1000
    } t_state;

endpackage

@@ sv/wrp_item_if.sv @@
interface wrp_item_if;
    logic                           valid;
    logic                           ready;
    logic [wrp_pkg::W_MODE-1:0]     mode;
    logic [wrp_pkg::W_MASK-1:0]     usable_mask;
    logic [wrp_pkg::W_WEIGHT-1:0]   weight_zero;
    logic [wrp_pkg::W_WEIGHT-1:0]   weight_one;
    logic [wrp_pkg::W_WEIGHT-1:0]   weight_two;
    logic [wrp_pkg::W_WEIGHT-1:0]   weight_three;
    logic [wrp_pkg::W_FRAC-1:0]     random_fraction;

    modport source (
        output valid, mode, usable_mask, weight_zero, weight_one, weight_two,
               weight_three, random_fraction,
        input  ready
    );
    modport sink (
        input  valid, mode, usable_mask, weight_zero, weight_one, weight_two,
               weight_three, random_fraction,
        output ready
    );
endinterface

@@ sv/wrp_res_if.sv @@
interface wrp_res_if;
    logic                           valid;
    logic                           ready;
    logic [wrp_pkg::W_IDX-1:0]      chosen;
    logic                           none_available;
    logic [wrp_pkg::W_MASK-1:0]     used_now;

    modport source (
        output valid, chosen, none_available, used_now,
        input  ready
    );
    modport sink (
        input  valid, chosen, none_available, used_now,
        output ready
    );
endinterface

@@ sv/wrp_ctrl.sv @@
`include "weighted_roulette_picker_assert.svh"

module wrp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  wrp_pkg::t_sts i_sts,
    output wrp_pkg::t_cmd o_cmd
);

    wrp_pkg::t_state r_state;
    wrp_pkg::t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = (r_state == wrp_pkg::S_IDLE);
        o_cmd        = '0;
        unique case (r_state)
            wrp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = wrp_pkg::S_SUM;
                end
            end
            wrp_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = wrp_pkg::S_MUL;
            end
            wrp_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = wrp_pkg::S_PICK;
            end
            wrp_pkg::S_PICK: begin
                // hold until the output register can take the beat
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = wrp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wrp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `WRP_ASSERT_NXT(a_capture_to_sum, i_clk, i_rst_n, o_cmd.capture, o_cmd.sum)
    `WRP_ASSERT_NXT(a_commit_to_idle, i_clk, i_rst_n, o_cmd.commit, o_in_ready)
    `WRP_ASSERT_IMP(a_single_cmd, i_clk, i_rst_n, o_cmd.capture,
                    !(o_cmd.sum || o_cmd.mul || o_cmd.commit))

endmodule

@@ sv/wrp_dpath.sv @@
`include "weighted_roulette_picker_assert.svh"

module wrp_dpath #(
    parameter int NUM_METHODS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wrp_pkg::t_item   i_item,
    input  wrp_pkg::t_cmd    i_cmd,
    output wrp_pkg::t_sts    o_sts,
    wrp_res_if.source        o_res
);

    localparam int N = wrp_pkg::MAX_METHODS;

    wrp_pkg::t_item                     r_item;
    logic [wrp_pkg::W_MASK-1:0]         r_used;
    logic [wrp_pkg::W_MASK-1:0]         n_used;
    logic [N-1:0]                       r_elig;
    logic [N-1:0][wrp_pkg::W_EFF-1:0]   r_wt;
    logic [wrp_pkg::W_TOTAL-1:0]        r_total;
    logic [wrp_pkg::W_PROD-1:0]         r_target;
    logic                               r_out_valid;
    logic [wrp_pkg::W_IDX-1:0]          r_chosen;
    logic                               r_none;

    logic [N-1:0]                       elig;
    logic [N-1:0][wrp_pkg::W_EFF-1:0]   wt_eff;
    logic [wrp_pkg::W_TOTAL-1:0]        total;
    logic [N-1:0][wrp_pkg::W_TOTAL-1:0] run;
    logic [N-1:0]                       hit;
    logic [wrp_pkg::W_IDX-1:0]          pick_idx;
    logic                               pick_found;
    logic [wrp_pkg::W_IDX-1:0]          n_chosen;
    logic                               n_none;

    // effective weights: zero counts as one, used or absent methods drop out
    always_comb begin
        total = '0;
        for (int i = 0; i < N; i++) begin
            elig[i] = (i < NUM_METHODS) && !r_used[i];
            if (!elig[i]) begin
                wt_eff[i] = '0;
            end else if (r_item.weight[i] == '0) begin
                wt_eff[i] = wrp_pkg::W_EFF'(1);
            end else begin
                wt_eff[i] = wrp_pkg::W_EFF'(r_item.weight[i]);
            end
            total = total + wrp_pkg::W_TOTAL'(wt_eff[i]);
        end
    end

    // running sums and the first eligible method that reaches the target
    always_comb begin
        pick_idx   = '0;
        pick_found = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (i == 0) begin
                run[i] = wrp_pkg::W_TOTAL'(r_wt[i]);
            end else begin
                run[i] = run[i-1] + wrp_pkg::W_TOTAL'(r_wt[i]);
            end
            hit[i] = r_elig[i] && ({run[i], {wrp_pkg::W_FRAC{1'b0}}} >= r_target);
        end
        for (int i = N - 1; i >= 0; i--) begin
            if (hit[i]) begin
                pick_idx   = wrp_pkg::W_IDX'(i);
                pick_found = 1'b1;
            end
        end
    end

    always_comb begin
        n_used   = r_used;
        n_chosen = '0;
        n_none   = 1'b0;
        unique case (r_item.mode)
            wrp_pkg::MODE_CLEAR: begin
                n_used = '0;
            end
            wrp_pkg::MODE_LOAD: begin
                n_used = ~r_item.usable_mask;
            end
            wrp_pkg::MODE_PICK: begin
                if (r_total == '0) begin
                    n_none = 1'b1;
                end else if (pick_found) begin
                    n_chosen           = pick_idx;
                    n_used[pick_idx]   = 1'b1;
                end
            end
            default: begin
                n_used = r_used;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.sum) begin
            r_elig  <= elig;
            r_wt    <= wt_eff;
            r_total <= total;
        end
        if (i_cmd.mul) begin
            r_target <= wrp_pkg::W_PROD'(r_item.random_fraction) * wrp_pkg::W_PROD'(r_total);
        end
        if (i_cmd.commit) begin
            r_chosen <= n_chosen;
            r_none   <= n_none;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy       = r_out_valid && !o_res.ready;
    assign o_res.valid          = r_out_valid;
    assign o_res.chosen         = r_chosen;
    assign o_res.none_available = r_none;
    assign o_res.used_now       = r_used;

    `WRP_ASSERT_IMP(a_pick_marks_one, i_clk, i_rst_n,
                    i_cmd.commit && r_item.mode == wrp_pkg::MODE_PICK && r_total != '0,
                    $countones(n_used) == $countones(r_used) + 1)
    `WRP_ASSERT_IMP(a_empty_keeps_used, i_clk, i_rst_n,
                    i_cmd.commit && n_none, n_used == r_used && n_chosen == '0)
    `WRP_ASSERT_IMP(a_commit_slot_free, i_clk, i_rst_n,
                    i_cmd.commit, !o_sts.out_busy)

endmodule

@@ sv/weighted_roulette_picker.sv @@
// A result beat becomes valid once its input beat has passed the capture, weight
// sum, 16x18 multiply, compare and select steps. No new item is taken until the
// last one is committed; a stalled result beat holds the select step until taken.
// Reset (synchronous, active low) clears the used mask, the controller state and
// the output valid; the block takes items as soon as reset is released.
module weighted_roulette_picker #(
    parameter int NUM_METHODS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wrp_item_if.sink   i_item,
    wrp_res_if.source  o_res
);

    wrp_pkg::t_item item;
    wrp_pkg::t_cmd  cmd;
    wrp_pkg::t_sts  sts;
    logic           in_ready;

    assign item.mode            = i_item.mode;
    assign item.usable_mask     = i_item.usable_mask;
    assign item.weight[0]       = i_item.weight_zero;
    assign item.weight[1]       = i_item.weight_one;
    assign item.weight[2]       = i_item.weight_two;
    assign item.weight[3]       = i_item.weight_three;
    assign item.random_fraction = i_item.random_fraction;
    assign i_item.ready         = in_ready;

    wrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wrp_dpath #(
        .NUM_METHODS (NUM_METHODS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_res)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int METHODS     = 4;
    localparam int TOTAL_ITEMS = 1250;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [wrp_pkg::W_IDX-1:0]  chosen;
        logic                       none_available;
        logic [wrp_pkg::W_MASK-1:0] used_now;
    } t_outcome;

    typedef struct {
        wrp_pkg::t_item item;
        bit             hold_for_drain;
    } t_entry;

    logic clk = 1'b0;
    logic rst_n;

    wrp_item_if item_bus();
    wrp_res_if  res_bus();

    weighted_roulette_picker #(
        .NUM_METHODS(METHODS)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_item (item_bus),
        .o_res  (res_bus)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    t_entry      item_q[$];
    t_outcome    outcome_q[$];
    logic [3:0]  model_used = '0;
    bit          drain_next = 1'b0;
    int          queued_items = 0;
    int          issued_items = 0;
    int          accepted_items = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic [1:0]  rx_style = '0;
    int          rx_left = 0;
    int          rx_hold = 0;

    function automatic logic [63:0] weight_or_one(input logic [wrp_pkg::W_WEIGHT-1:0] w);
        return (w == '0) ? 64'd1 : 64'(w);
    endfunction

    // Roulette pick without replacement; updates the model's used mask.
    function automatic t_outcome roulette_outcome(input wrp_pkg::t_item it);
        t_outcome    r;
        logic [63:0] total;
        logic [63:0] target;
        logic [63:0] run;
        bit          found;
        int          i;
        r = '0;
        case (it.mode)
            wrp_pkg::MODE_CLEAR: model_used = '0;
            wrp_pkg::MODE_LOAD:  model_used = ~it.usable_mask;
            wrp_pkg::MODE_PICK: begin
                total = '0;
                for (i = 0; i < METHODS; i++)
                    if (!model_used[i]) total += weight_or_one(it.weight[i]);
                if (total == '0) begin
                    r.none_available = 1'b1;
                end else begin
                    target = 64'(it.random_fraction) * total;
                    run    = '0;
                    found  = 1'b0;
                    for (i = 0; i < METHODS; i++) begin
                        if (!found && !model_used[i]) begin
                            run += weight_or_one(it.weight[i]);
                            if ((run << 16) >= target) begin
                                r.chosen = wrp_pkg::W_IDX'(i);
                                found    = 1'b1;
                            end
                        end
                    end
                    model_used[r.chosen] = 1'b1;
                end
            end
            default: ;
        endcase
        r.used_now = model_used;
        return r;
    endfunction

    function automatic logic [wrp_pkg::W_WEIGHT-1:0] rand_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return wrp_pkg::W_WEIGHT'($urandom_range(1, 4));
            default: return wrp_pkg::W_WEIGHT'($urandom);
        endcase
    endfunction

    function automatic logic [wrp_pkg::W_FRAC-1:0] rand_fraction();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return wrp_pkg::W_FRAC'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic [wrp_pkg::W_MODE-1:0]   mode,
                              input logic [wrp_pkg::W_MASK-1:0]   mask,
                              input logic [wrp_pkg::W_WEIGHT-1:0] w0,
                              input logic [wrp_pkg::W_WEIGHT-1:0] w1,
                              input logic [wrp_pkg::W_WEIGHT-1:0] w2,
                              input logic [wrp_pkg::W_WEIGHT-1:0] w3,
                              input logic [wrp_pkg::W_FRAC-1:0]   frac);
        t_entry e;
        e.item.mode            = mode;
        e.item.usable_mask     = mask;
        e.item.weight[0]       = w0;
        e.item.weight[1]       = w1;
        e.item.weight[2]       = w2;
        e.item.weight[3]       = w3;
        e.item.random_fraction = frac;
        e.hold_for_drain       = drain_next;
        drain_next             = 1'b0;
        item_q.push_back(e);
        queued_items++;
    endtask

    // Sender: bursts of beats separated by random gaps.
    always @(negedge clk) begin : drive_proc
        t_entry beat;
        if (rst_n) begin
            if (item_bus.valid && issued_items != accepted_items) begin
                // hold the beat until it is taken
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                item_bus.valid <= 1'b0;
            end else if (item_q.size() == 0 ||
                         (item_q[0].hold_for_drain && outcome_q.size() != 0)) begin
                item_bus.valid <= 1'b0;
            end else begin
                beat = item_q.pop_front();
                item_bus.mode            <= beat.item.mode;
                item_bus.usable_mask     <= beat.item.usable_mask;
                item_bus.weight_zero     <= beat.item.weight[0];
                item_bus.weight_one      <= beat.item.weight[1];
                item_bus.weight_two      <= beat.item.weight[2];
                item_bus.weight_three    <= beat.item.weight[3];
                item_bus.random_fraction <= beat.item.random_fraction;
                item_bus.valid           <= 1'b1;
                issued_items             <= issued_items + 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: switch between randomly chosen stall styles when rx_left runs out.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_style <= 2'($urandom_range(0, 3));
            rx_left  <= 300;
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            2'd0: res_bus.ready <= 1'b1;
            2'd1: res_bus.ready <= 1'($urandom_range(0, 1));
            2'd2: res_bus.ready <= (rx_left % 4 == 0);
            default: begin
                if (rx_hold == 0) begin
                    res_bus.ready <= ~res_bus.ready;
                    rx_hold       <= $urandom_range(1, 20);
                end else begin
                    rx_hold <= rx_hold - 1;
                end
            end
        endcase
    end

    always @(posedge clk) begin : check_proc
        wrp_pkg::t_item it;
        t_outcome       want;
        t_outcome       got;
        bit             moved;
        moved = 1'b0;
        if (rst_n) begin
            // check the result beat first so a new input cannot mask a stray one
            if (res_bus.valid && res_bus.ready) begin
                moved = 1'b1;
                got.chosen         = res_bus.chosen;
                got.none_available = res_bus.none_available;
                got.used_now       = res_bus.used_now;
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat: chosen=%0d none=%0b used=%b",
                                 $realtime, got.chosen, got.none_available, got.used_now);
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp %0d/%0b/%b got %0d/%0b/%b",
                                     $realtime, want.chosen, want.none_available,
                                     want.used_now, got.chosen, got.none_available,
                                     got.used_now);
                    end
                end
            end
            if (item_bus.valid && item_bus.ready) begin
                moved = 1'b1;
                it.mode            = item_bus.mode;
                it.usable_mask     = item_bus.usable_mask;
                it.weight[0]       = item_bus.weight_zero;
                it.weight[1]       = item_bus.weight_one;
                it.weight[2]       = item_bus.weight_two;
                it.weight[3]       = item_bus.weight_three;
                it.random_fraction = item_bus.random_fraction;
                outcome_q.push_back(roulette_outcome(it));
                accepted_items <= accepted_items + 1;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin
        int picks;
        rst_n                    = 1'b0;
        item_bus.valid           = 1'b0;
        item_bus.mode            = wrp_pkg::MODE_PICK;
        item_bus.usable_mask     = '0;
        item_bus.weight_zero     = '0;
        item_bus.weight_one      = '0;
        item_bus.weight_two      = '0;
        item_bus.weight_three    = '0;
        item_bus.random_fraction = '0;
        res_bus.ready            = 1'b0;

        // directed: zero weights, full weights, exact boundaries, empty sets, load extremes
        queue_item(wrp_pkg::MODE_CLEAR, 4'hF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        queue_item(wrp_pkg::MODE_PICK,  4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_item(wrp_pkg::MODE_PICK,  4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_item(wrp_pkg::MODE_PICK,  4'h5, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'h8000);
        queue_item(wrp_pkg::MODE_PICK,  4'hA, 16'h1234, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001);
        queue_item(wrp_pkg::MODE_PICK,  4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        queue_item(wrp_pkg::MODE_LOAD,  4'h0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        queue_item(wrp_pkg::MODE_PICK,  4'hF, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0000);
        queue_item(wrp_pkg::MODE_LOAD,  4'hF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_item(wrp_pkg::MODE_PICK,  4'h0, 16'h0001, 16'h0001, 16'h0001, 16'hFFFF, 16'h0001);
        queue_item(wrp_pkg::MODE_PICK,  4'h0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        queue_item(wrp_pkg::MODE_LOAD,  4'hA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        queue_item(wrp_pkg::MODE_PICK,  4'h0, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0000);
        queue_item(wrp_pkg::MODE_PICK,  4'h0, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'hFFFF);
        queue_item(wrp_pkg::MODE_PICK,  4'h0, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h4000);
        queue_item(wrp_pkg::MODE_LOAD,  4'h1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        queue_item(wrp_pkg::MODE_PICK,  4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_item(wrp_pkg::MODE_CLEAR, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // running sum lands exactly on the target at method 2
        queue_item(wrp_pkg::MODE_PICK,  4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hC000);
        queue_item(wrp_pkg::MODE_PICK,  4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h4000);
        queue_item(wrp_pkg::MODE_PICK,  4'h0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8001);

        // drain everything before the random part starts
        drain_next = 1'b1;
        while (queued_items < TOTAL_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1: queue_item(wrp_pkg::W_MODE'($urandom_range(0, 2)),
                                 wrp_pkg::W_MASK'($urandom_range(0, 15)),
                                 rand_weight(), rand_weight(), rand_weight(), rand_weight(),
                                 rand_fraction());
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        queue_item(wrp_pkg::MODE_CLEAR, wrp_pkg::W_MASK'($urandom_range(0, 15)),
                                   rand_weight(), rand_weight(), rand_weight(), rand_weight(),
                                   rand_fraction());
                    else
                        queue_item(wrp_pkg::MODE_LOAD, wrp_pkg::W_MASK'($urandom_range(0, 15)),
                                   rand_weight(), rand_weight(), rand_weight(), rand_weight(),
                                   rand_fraction());
                    picks = $urandom_range(1, 5);
                    repeat (picks)
                        queue_item(wrp_pkg::MODE_PICK, wrp_pkg::W_MASK'($urandom_range(0, 15)),
                                   rand_weight(), rand_weight(), rand_weight(), rand_weight(),
                                   rand_fraction());
                end
            endcase
            if ($urandom_range(0, 49) == 0) drain_next = 1'b1;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while ((accepted_items < queued_items || outcome_q.size() != 0) &&
               idle_cycles < STALL_LIMIT)
            @(posedge clk);

        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
        end else begin
            repeat (SETTLE) @(posedge clk);
            if (mismatches == 0 && outcome_q.size() == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
